FILE: rtl/gcode_line_parser_macros.svh
// Assertion macros shared by the G-code line parser modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef GCODE_LINE_PARSER_MACROS_SVH
`define GCODE_LINE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define GCLP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define GCLP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define GCLP_ASSERT(lbl, clk, rstn, prop, msg)
`define GCLP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: rtl/gclp_pkg.sv
// Types, character codes and constants of the G-code line parser.
// Used by gclp_core, gclp_res_fifo and gcode_line_parser; depends on nothing.
package gclp_pkg;

  localparam int unsigned MaxWordChars = 32;
  localparam int unsigned CntW         = $clog2(MaxWordChars);
  localparam logic [CntW-1:0] CntLimit = CntW'(MaxWordChars - 1);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam logic [31:0] MagMax   = 32'h8000_0000;
  localparam logic [31:0] MaxPos   = 32'h7fff_ffff;
  localparam logic [31:0] ImagSat  = 32'd2147483000;
  localparam logic [21:0] IpartSat = 22'd2147483;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharStar  = 8'h2a;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharPoint = 8'h2e;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSemi  = 8'h3b;
  localparam logic [7:0] CharG     = 8'h47;
  localparam logic [7:0] CharM     = 8'h4d;
  localparam logic [7:0] CharN     = 8'h4e;
  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] CharT     = 8'h54;

  typedef enum logic [6:0] {
    ST_TYPE   = 7'b0000001,
    ST_CODE   = 7'b0000010,
    ST_PTYPE  = 7'b0000100,
    ST_PARAM  = 7'b0001000,
    ST_LINE   = 7'b0010000,
    ST_SUM    = 7'b0100000,
    ST_IGNORE = 7'b1000000
  } parse_state_e;

  typedef enum logic [2:0] {
    KIND_LINE  = 3'd0,
    KIND_CODE  = 3'd1,
    KIND_PARAM = 3'd2,
    KIND_SUM   = 3'd3,
    KIND_EOL   = 3'd4,
    KIND_ERR   = 3'd5
  } res_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BAD_TYPE = 3'd1,
    ERR_EMPTY_CODE  = 3'd2,
    ERR_EMPTY_PARAM = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_code_e;

  typedef struct packed {
    res_kind_e   kind;
    logic [7:0]  letter;
    logic [31:0] value;
    err_code_e   err_code;
    logic [7:0]  xor_sum;
    logic        sum_found;
    logic        sum_match;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [6:0] frac_scale(logic [1:0] fd);
    logic [6:0] s;
    case (fd)
      2'd0:    s = 7'd100;
      2'd1:    s = 7'd10;
      default: s = 7'd1;
    endcase
    return s;
  endfunction

  function automatic result_t mk_res(res_kind_e kind, logic [7:0] letter, logic [31:0] value,
                                     err_code_e err, logic [7:0] xs, logic found,
                                     logic match);
    result_t r;
    r.kind      = kind;
    r.letter    = letter;
    r.value     = value;
    r.err_code  = err;
    r.xor_sum   = xs;
    r.sum_found = found;
    r.sum_match = match;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/gclp_core.sv
// Parser state and per-character decode of the G-code line parser.
// Depends on gclp_pkg and gcode_line_parser_macros.svh.
`include "gcode_line_parser_macros.svh"
module gclp_core
  import gclp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_i,
  output push_t      push_o
);

  parse_state_e    st_q, st_d;
  logic [31:0]     accum_q, accum_d;
  logic [31:0]     imag_q, imag_d;
  logic [21:0]     ipart_q, ipart_d;
  logic [1:0]      fd_q, fd_d;
  logic            pt_q, pt_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      cur_q, cur_d;
  logic [7:0]      xor_q, xor_d;
  logic            star_q, star_d;
  logic            err_q, err_d;

  logic            eol, star_act, is_digit;
  logic [3:0]      dig;
  logic [35:0]     m_int;
  logic [32:0]     m_frac;
  logic [31:0]     ac_accum, ac_imag;
  logic [21:0]     ac_ipart;
  logic [25:0]     ipart_x10;
  logic [1:0]      ac_fd;
  logic            ac_pt, ac_neg;
  res_kind_e       wk;
  logic            fin_ok, int_word, match;
  logic [31:0]     mag, wval;
  result_t         word_res, eol_res, r0, r1;
  logic [1:0]      n;
  logic            emit;

  assign eol      = (char_i == CharNul) || (char_i == CharLf) || (char_i == CharCr);
  assign star_act = (char_i == CharStar) && (st_q != ST_SUM) && (st_q != ST_IGNORE);
  assign is_digit = (char_i >= CharZero) && (char_i <= CharNine);
  assign dig      = 4'(char_i - CharZero);
  assign xor_d    = eol ? xor_q : ((!star_q && !star_act) ? (xor_q ^ char_i) : xor_q);
  assign match    = star_q && !err_q && !neg_q && (ipart_q == {14'd0, xor_q});

  // Value update for one character added to the pending word.
  always_comb begin
    m_int     = 36'({accum_q, 3'b000}) + 36'({accum_q, 1'b0}) + 36'(14'(dig) * 14'd1000);
    m_frac    = 33'(accum_q) + 33'(10'(dig) * 10'(frac_scale(fd_q)));
    ipart_x10 = 26'({ipart_q, 3'b000}) + 26'({ipart_q, 1'b0}) + 26'(dig);
    ac_accum  = accum_q;
    ac_imag   = imag_q;
    ac_ipart  = ipart_q;
    ac_fd     = fd_q;
    ac_pt     = pt_q;
    ac_neg    = neg_q;
    if (char_i == CharMinus && cnt_q == '0) begin
      ac_neg = 1'b1;
    end else if (char_i == CharPoint && !pt_q) begin
      ac_pt = 1'b1;
    end else if (is_digit) begin
      if (!pt_q) begin
        if (m_int > 36'(MagMax)) begin
          ac_accum = MagMax;
          ac_imag  = ImagSat;
          ac_ipart = IpartSat;
        end else begin
          ac_accum = m_int[31:0];
          ac_imag  = m_int[31:0];
          ac_ipart = ipart_x10[21:0];
        end
      end else if (fd_q != 2'd3) begin
        ac_accum = (m_frac > 33'(MagMax)) ? MagMax : m_frac[31:0];
        ac_fd    = fd_q + 2'd1;
      end
    end
  end

  // Result for the pending word of the current state.
  always_comb begin
    fin_ok = 1'b0;
    case (st_q)
      ST_CODE: begin
        wk     = KIND_CODE;
        fin_ok = cnt_q != '0;
      end
      ST_PARAM: begin
        wk     = KIND_PARAM;
        fin_ok = cnt_q != '0;
      end
      ST_LINE: begin
        wk     = KIND_LINE;
        fin_ok = cnt_q != '0;
      end
      ST_SUM: begin
        wk     = KIND_SUM;
        fin_ok = 1'b1;
      end
      default: wk = KIND_CODE;
    endcase
    int_word = (wk == KIND_LINE) || (wk == KIND_CODE) || (cur_q == CharT) || (cur_q == CharP);
    mag      = int_word ? imag_q : accum_q;
    if (wk == KIND_SUM) begin
      wval = neg_q ? (32'd0 - {10'd0, ipart_q}) : {10'd0, ipart_q};
    end else begin
      wval = neg_q ? (32'd0 - mag) : (mag[31] ? MaxPos : mag);
    end
    word_res = mk_res(wk, cur_q, wval, ERR_NONE, xor_d, star_q, 1'b0);
    eol_res  = mk_res(KIND_EOL, CharNul, 32'd0, ERR_NONE, xor_q, star_q, match);
  end

  always_comb begin
    st_d    = st_q;
    accum_d = accum_q;
    imag_d  = imag_q;
    ipart_d = ipart_q;
    fd_d    = fd_q;
    pt_d    = pt_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    star_d  = star_q;
    err_d   = err_q;
    r0      = word_res;
    r1      = eol_res;
    n       = 2'd0;
    emit    = 1'b0;

    if (eol) begin
      if (st_q != ST_IGNORE && fin_ok) begin
        n = 2'd2;
      end else begin
        r0 = eol_res;
        n  = 2'd1;
      end
      st_d   = ST_TYPE;
      cur_d  = CharNul;
      star_d = 1'b0;
      err_d  = 1'b0;
      accum_d = '0;
      imag_d  = '0;
      ipart_d = '0;
      fd_d    = '0;
      pt_d    = 1'b0;
      neg_d   = 1'b0;
      cnt_d   = '0;
    end else if (star_act) begin
      n       = {1'b0, fin_ok};
      accum_d = '0;
      imag_d  = '0;
      ipart_d = '0;
      fd_d    = '0;
      pt_d    = 1'b0;
      neg_d   = 1'b0;
      cnt_d   = '0;
      star_d  = 1'b1;
      cur_d   = CharStar;
      st_d    = ST_SUM;
    end else if (char_i == CharSemi && st_q != ST_IGNORE) begin
      n    = {1'b0, fin_ok};
      emit = fin_ok;
      st_d = ST_IGNORE;
    end else begin
      case (st_q)
        ST_TYPE: begin
          if (char_i == CharSpace) begin
            st_d = ST_TYPE;
          end else if (char_i == CharN) begin
            cur_d = CharN;
            st_d  = ST_LINE;
          end else if (char_i == CharG || char_i == CharM) begin
            cur_d = char_i;
            st_d  = ST_CODE;
          end else begin
            r0    = mk_res(KIND_ERR, char_i, 32'd0, ERR_BAD_TYPE, xor_d, star_q, 1'b0);
            n     = 2'd1;
            err_d = 1'b1;
            st_d  = ST_IGNORE;
          end
        end
        ST_PTYPE: begin
          if (char_i != CharSpace) begin
            cur_d = char_i;
            st_d  = ST_PARAM;
          end
        end
        ST_CODE, ST_PARAM, ST_LINE, ST_SUM: begin
          if (char_i == CharSpace) begin
            if (fin_ok || st_q == ST_LINE) begin
              n    = 2'd1;
              emit = 1'b1;
              st_d = (st_q == ST_LINE) ? ST_TYPE : ((st_q == ST_SUM) ? ST_IGNORE : ST_PTYPE);
            end else begin
              r0    = mk_res(KIND_ERR, char_i, 32'd0,
                             (st_q == ST_CODE) ? ERR_EMPTY_CODE : ERR_EMPTY_PARAM,
                             xor_d, star_q, 1'b0);
              n     = 2'd1;
              err_d = 1'b1;
              st_d  = ST_IGNORE;
            end
          end else if (cnt_q >= CntLimit) begin
            r0    = mk_res(KIND_ERR, char_i, 32'd0, ERR_OVERFLOW, xor_d, star_q, 1'b0);
            n     = 2'd1;
            err_d = 1'b1;
            st_d  = ST_IGNORE;
          end else begin
            accum_d = ac_accum;
            imag_d  = ac_imag;
            ipart_d = ac_ipart;
            fd_d    = ac_fd;
            pt_d    = ac_pt;
            neg_d   = ac_neg;
            cnt_d   = cnt_q + CntW'(1);
          end
        end
        default: st_d = st_q;
      endcase
    end

    // The checksum keeps its value and sign for the end-of-line compare.
    if (emit) begin
      cnt_d = '0;
      if (st_q != ST_SUM) begin
        accum_d = '0;
        imag_d  = '0;
        ipart_d = '0;
        fd_d    = '0;
        pt_d    = 1'b0;
        neg_d   = 1'b0;
      end
    end

    if (n == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_TYPE;
      accum_q <= '0;
      imag_q  <= '0;
      ipart_q <= '0;
      fd_q    <= '0;
      pt_q    <= 1'b0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      cur_q   <= '0;
      xor_q   <= '0;
      star_q  <= 1'b0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      st_q    <= st_d;
      accum_q <= accum_d;
      imag_q  <= imag_d;
      ipart_q <= ipart_d;
      fd_q    <= fd_d;
      pt_q    <= pt_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      xor_q   <= eol ? 8'd0 : xor_d;
      star_q  <= star_d;
      err_q   <= err_d;
    end
  end

  assign push_o.n  = accept_i ? n : 2'd0;
  assign push_o.r0 = r0;
  assign push_o.r1 = r1;

  `GCLP_ASSERT(a_star_state, clk_i, rst_ni, star_q |-> (st_q == ST_SUM || st_q == ST_IGNORE), "checksum seen outside checksum or ignore state")
  `GCLP_ASSERT(a_err_state, clk_i, rst_ni, err_q |-> (st_q == ST_IGNORE), "error latched but line not ignored")
  `GCLP_ASSERT(a_two_eol, clk_i, rst_ni, (push_o.n == 2'd2) |-> (push_o.r1.kind == KIND_EOL), "second result of a character is not end of line")

endmodule

FILE: rtl/gclp_res_fifo.sv
// Four-entry result queue of the G-code line parser, two writes and one read per cycle.
// Depends on gclp_pkg and gcode_line_parser_macros.svh.
`include "gcode_line_parser_macros.svh"
module gclp_res_fifo
  import gclp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  result_t           mem_q [FifoDepth];
  logic [FifoAw-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FifoAw:0]   cnt_q, cnt_d;
  logic              pop;

  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rp_q];
  assign room_o      = cnt_q <= (FifoAw + 1)'(FifoDepth - 2);
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wp_d  = wp_q + FifoAw'(push_i.n);
    rp_d  = rp_q + FifoAw'(pop);
    cnt_d = cnt_q + (FifoAw + 1)'(push_i.n) - (FifoAw + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wp_q + FifoAw'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  `GCLP_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > (FifoAw + 1)'(FifoDepth), "result queue count out of range")
  `GCLP_ASSERT(a_push_room, clk_i, rst_ni, (push_i.n != 2'd0) |-> room_o, "results pushed without room")
  `GCLP_ASSERT(a_push_shows, clk_i, rst_ni, (cnt_q == '0 && push_i.n != 2'd0) |=> out_valid_o, "pushed result not presented")

endmodule

FILE: rtl/gcode_line_parser.sv
// G-code line parser with XOR checksum: top level.
// Instantiates gclp_core and gclp_res_fifo; depends on gclp_pkg.
//
// One character is taken per cycle whenever the four-entry result queue has room for two
// results, so a line streams in at one character a cycle. Each character yields zero, one or
// two results (two only at end of line with a word pending), queued as the character is taken;
// the queue drains one result per cycle while the output is ready, which sets the sustained
// rate when most characters finish a word. Values are signed thousandths that saturate; after
// an error the rest of the line is ignored until an end-of-line character clears all state.
module gcode_line_parser
  import gclp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  letter_o,
  output logic signed [31:0] value_o,
  output logic [2:0]  err_code_o,
  output logic [7:0]  xor_sum_o,
  output logic        sum_found_o,
  output logic        sum_match_o,
  output logic        last_o
);

  push_t   push;
  result_t res;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  gclp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (char_in_i),
    .push_o   (push)
  );

  gclp_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign kind_o      = res.kind;
  assign letter_o    = res.letter;
  assign value_o     = res.value;
  assign err_code_o  = res.err_code;
  assign xor_sum_o   = res.xor_sum;
  assign sum_found_o = res.sum_found;
  assign sum_match_o = res.sum_match;
  assign last_o      = res.last;

endmodule
